[hw/rtl/ols_pkg.sv]
// ----------------------------------------------------------------------------
// ols_pkg: shared constants and types for the ordered list store
// Store geometry, request and status codes, and the conversion helpers
// between the 32-bit port values and the stored word width.
// ----------------------------------------------------------------------------
package ols_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// field widths fixed by the port definition
	localparam int REQ_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 6;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 7;

	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [VALUE_W-1:0]    value_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		data_t             wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		value_t              data;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} result_t;

	// port value -> stored word (sign-extend or cut)
	function automatic data_t to_store(value_t v);
		to_store = data_t'(v);
	endfunction

	// stored word -> port value (sign-extend or cut)
	function automatic value_t from_store(data_t d);
		from_store = value_t'(d);
	endfunction

endpackage

[hw/rtl/ols_mem.sv]
// ----------------------------------------------------------------------------
// ols_mem: entry storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ols_mem
	import ols_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output data_t    rdata
);

	data_t mem_q [CAPACITY];
	data_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/ols_seq.sv]
// ----------------------------------------------------------------------------
// ols_seq: request sequencer
// Remove walks the store one entry at a time through the single read
// port and the shared equality compare: scan for the first match, then
// shift the tail left one word at a time, a read state then a write state.
// ----------------------------------------------------------------------------
module ols_seq
	import ols_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [REQ_W-1:0]   req_type,
	input  value_t             value,
	input  logic [INDEX_W-1:0] index,
	output mem_req_t           mem_req,
	input  data_t              mem_rdata,
	output logic               push_valid,
	input  logic               push_ready,
	output result_t            result
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_SCAN_RD  = 8'b0000_0010,
		S_SCAN_CMP = 8'b0000_0100,
		S_SHIFT_RD = 8'b0000_1000,
		S_SHIFT_WR = 8'b0001_0000,
		S_READ_RD  = 8'b0010_0000,
		S_READ_DAT = 8'b0100_0000,
		S_PUSH     = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    fill_q;
	logic [ADDR_W-1:0]   ptr_q;
	data_t               val_q;
	value_t              res_data_q;
	logic [STATUS_W-1:0] res_status_q;

	logic             accept;
	logic             not_full;
	logic [CNT_W-1:0] ptr_p1;
	logic [CNT_W-1:0] ptr_p2;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign not_full = (fill_q < CNT_W'(CAPACITY));
	assign ptr_p1   = CNT_W'(ptr_q) + CNT_W'(1);
	assign ptr_p2   = CNT_W'(ptr_q) + CNT_W'(2);

	always_comb begin
		mem_req       = '0;
		mem_req.we    = (accept && req_type == REQ_APPEND && not_full) ||
		                (state_q == S_SHIFT_WR);
		mem_req.waddr = (state_q == S_IDLE) ? fill_q[ADDR_W-1:0] : ptr_q;
		mem_req.wdata = (state_q == S_IDLE) ? to_store(value) : mem_rdata;
		mem_req.re    = (state_q == S_SCAN_RD) || (state_q == S_SHIFT_RD) ||
		                (state_q == S_READ_RD);
		mem_req.raddr = (state_q == S_SHIFT_RD) ? ptr_q + ADDR_W'(1) : ptr_q;
	end

	assign push_valid    = (state_q == S_PUSH);
	assign result.data   = res_data_q;
	assign result.status = res_status_q;
	assign result.count  = COUNT_W'(fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req_type)
							REQ_APPEND: begin
								if (not_full) begin
									fill_q <= fill_q + CNT_W'(1);
								end
								state_q <= S_PUSH;
							end
							REQ_REMOVE: begin
								state_q <= (fill_q == '0) ? S_PUSH : S_SCAN_RD;
							end
							REQ_READ: begin
								if (32'(index) < 32'(fill_q)) begin
									state_q <= S_READ_RD;
								end else begin
									state_q <= S_PUSH;
								end
							end
							default: state_q <= S_PUSH;
						endcase
					end
				end
				S_SCAN_RD:  state_q <= S_SCAN_CMP;
				S_SCAN_CMP: begin
					if (mem_rdata == val_q) begin
						if (ptr_p1 < fill_q) begin
							state_q <= S_SHIFT_RD;
						end else begin
							fill_q  <= fill_q - CNT_W'(1);
							state_q <= S_PUSH;
						end
					end else if (ptr_p1 < fill_q) begin
						state_q <= S_SCAN_RD;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_SHIFT_RD: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: begin
					if (ptr_p2 < fill_q) begin
						state_q <= S_SHIFT_RD;
					end else begin
						fill_q  <= fill_q - CNT_W'(1);
						state_q <= S_PUSH;
					end
				end
				S_READ_RD:  state_q <= S_READ_DAT;
				S_READ_DAT: state_q <= S_PUSH;
				S_PUSH: begin
					if (push_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: pointer, search key and result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q        <= to_store(value);
					res_data_q   <= '0;
					res_status_q <= ST_OK;
					ptr_q        <= '0;
					unique case (req_type)
						REQ_APPEND: begin
							if (!not_full) begin
								res_status_q <= ST_FULL;
							end
						end
						REQ_REMOVE: begin
							if (fill_q == '0) begin
								res_status_q <= ST_EMPTY;
							end
						end
						REQ_READ: begin
							ptr_q <= ADDR_W'(index);
							if (!(32'(index) < 32'(fill_q))) begin
								res_data_q   <= '1;
								res_status_q <= ST_RANGE;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN_CMP: begin
				if (mem_rdata != val_q) begin
					if (ptr_p1 < fill_q) begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end else begin
						res_status_q <= ST_NOTFOUND;
					end
				end
			end
			S_SHIFT_WR: ptr_q      <= ptr_q + ADDR_W'(1);
			S_READ_DAT: res_data_q <= from_store(mem_rdata);
			default: ;
		endcase
	end

endmodule

[hw/rtl/ordered_list_store_unit.sv]
// ----------------------------------------------------------------------------
// ordered_list_store_unit: ordered list of signed values in a fixed store
// Append, remove-first-match and read-at-index on a list of up to 64 words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one request item (req_type,
//   value, index); output channel out_valid/out_ready returns one result
//   item (read_data, status, count) for every request, in order.
//   in_ready is high only while the sequencer is idle; one request is
//   worked on at a time.
//   Append and rejected requests go straight to the result; a read passes
//   through a read state and a data state; a remove scans entries up to
//   the first match, then shifts each later entry one place left. Remove
//   time grows with the count, since the scan and the shift both go through
//   the single memory read port, one word at a time.
//   The result sits in an output register, so a new request is taken while
//   the previous result waits; if the receiver stalls, the next finished
//   result waits in the sequencer and in_ready stays low.
//   Reset empties the list (count 0); stored words are not cleared and are
//   never read before they are written.
// ----------------------------------------------------------------------------
module ordered_list_store_unit
	import ols_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [REQ_W-1:0]    req_type,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [INDEX_W-1:0]  index,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [VALUE_W-1:0] read_data,
	output logic [STATUS_W-1:0] status,
	output logic [COUNT_W-1:0]  count
);

	mem_req_t mem_req;
	data_t    mem_rdata;
	logic     push_valid;
	logic     push_ready;
	result_t  result;

	logic    out_valid_q;
	result_t out_q;

	ols_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	ols_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.value      (value),
		.index      (index),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.result     (result)
	);

	assign push_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_ready) begin
			out_valid_q <= push_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = out_q.data;
	assign status    = out_q.status;
	assign count     = out_q.count;

endmodule

[hw/rtl/ols_check.sv]
// ----------------------------------------------------------------------------
// ols_check: port-level checks for the ordered list store
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module ols_check
	import ols_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic signed [VALUE_W-1:0] read_data,
	input logic [STATUS_W-1:0] status,
	input logic [COUNT_W-1:0]  count
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) &&
		$stable(status) && $stable(count))
		else $error("result changed while stalled");

	// one request at a time: busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accepting an item");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(count) <= CAPACITY)
		else $error("count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> 32'(count) == CAPACITY)
		else $error("full status without a full store");

	a_range_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_RANGE |-> read_data == '1)
		else $error("out of range read without all-ones data");

endmodule

bind ordered_list_store_unit ols_check u_ols_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.read_data (read_data),
	.status    (status),
	.count     (count)
);
